/* hdl/pmc_pkg.sv */
// shared types and constants for the parse memo cache
`default_nettype none
package pmc_pkg;

    localparam int ENTRIES     = 256;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int POS_SHIFT   = 3;
    localparam int RULE_SHIFT  = 5;
    localparam int HASH_W      = 32 + POS_SHIFT;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-1:0] BUCKET_MASK       = HASH_W'(ENTRIES - 1);
    localparam logic [23:0]       STORE_COUNT_LIMIT = 24'd128;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_INVAL  = 2'd2;

    typedef logic [IDX_W-1:0] bucket_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_STORE,
        OP_INVAL
    } op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        position;
        logic [15:0]        rule_id;
        logic signed [31:0] match_result;
        logic [23:0]        record_start;
        logic [23:0]        record_count;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] cached_result;
        logic [23:0]        cached_start;
        logic [23:0]        cached_count;
        logic [31:0]        hits_so_far;
    } result_t;

    // classified transaction handed from front to back
    typedef struct packed {
        op_t                op;
        bucket_t            bucket;
        logic [31:0]        position;
        logic [15:0]        rule_id;
        logic signed [31:0] match_result;
        logic [23:0]        record_start;
        logic [23:0]        record_count;
    } job_t;

    typedef struct packed {
        logic [31:0]        position;
        logic [15:0]        rule_id;
        logic signed [31:0] result;
        logic [23:0]        start;
        logic [23:0]        count;
        logic [31:0]        generation;
    } entry_t;

endpackage
`default_nettype wire

/* hdl/pmc_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none
module pmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hdl/pmc_front.sv */
// front end: accepts transactions, hashes and classifies them, queues them for the back end
`default_nettype none
module pmc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire pmc_pkg::item_t item,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    output logic                job_valid,
    output pmc_pkg::job_t       job,
    input  wire logic           job_pop
);
    import pmc_pkg::*;

    logic              disabled_reg;
    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [HASH_W-1:0] hash_full;
    logic              store_skip;
    logic              push;
    logic              pop;
    job_t              job_in;

    assign busy      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign job_valid = (count_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        hash_full  = (HASH_W'(item.position) << POS_SHIFT)
                   ^ HASH_W'(item.rule_id >> RULE_SHIFT);
        // a positive match with too many records is never cached
        store_skip = disabled_reg
                   || ((item.match_result > 32'sd0) && (item.record_count > STORE_COUNT_LIMIT));

        job_in.bucket       = IDX_W'(hash_full & BUCKET_MASK);
        job_in.position     = item.position;
        job_in.rule_id      = item.rule_id;
        job_in.match_result = item.match_result;
        job_in.record_start = item.record_start;
        job_in.record_count = item.record_count;
        case (item.mode)
            MODE_LOOKUP: job_in.op = disabled_reg ? OP_NONE : OP_LOOKUP;
            MODE_STORE:  job_in.op = store_skip ? OP_NONE : OP_STORE;
            MODE_INVAL:  job_in.op = OP_INVAL;
            default:     job_in.op = OP_NONE;
        endcase

        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                disabled_reg <= cfg_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= job_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> job_valid)
        else $error("accepted transaction not visible to back end");

    a_last_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == QCNT_W'(1)) |=> !job_valid)
        else $error("queue not empty after last pop");

endmodule
`default_nettype wire

/* hdl/pmc_back.sv */
// back end: memory access, tag compare, hit count and result register
`default_nettype none
module pmc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire pmc_pkg::job_t job,
    output logic               job_pop,
    output logic               done,
    output pmc_pkg::result_t   result
);
    import pmc_pkg::*;

    logic        valid_reg [ENTRIES];
    logic [31:0] generation_reg;
    logic [31:0] hit_total_reg;
    logic [31:0] hit_total_next;

    // compare stage
    logic        pend_valid_reg;
    op_t         pend_op_reg;
    logic        pend_entry_valid_reg;
    logic [31:0] pend_position_reg;
    logic [15:0] pend_rule_reg;

    logic        done_reg;
    result_t     result_reg;

    entry_t      wr_entry;
    entry_t      rd_entry;
    logic        ram_we;
    logic        hit;

    // the back end never stalls
    assign job_pop = job_valid;
    assign ram_we  = job_valid && (job.op == OP_STORE);

    always_comb
    begin
        wr_entry.position   = job.position;
        wr_entry.rule_id    = job.rule_id;
        wr_entry.result     = job.match_result;
        wr_entry.start      = job.record_start;
        wr_entry.count      = job.record_count;
        wr_entry.generation = generation_reg;

        // an invalidate in the access stage only takes effect after this compare
        hit = pend_valid_reg && (pend_op_reg == OP_LOOKUP) && pend_entry_valid_reg
            && (rd_entry.generation == generation_reg)
            && (rd_entry.rule_id == pend_rule_reg)
            && (rd_entry.position == pend_position_reg);
        hit_total_next = hit_total_reg + 32'(hit);
    end

    pmc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (job.bucket),
        .wr_data (wr_entry),
        .rd_addr (job.bucket),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            generation_reg <= '0;
            hit_total_reg  <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[job.bucket] <= 1'b1;
            end
            if (job_valid && (job.op == OP_INVAL))
            begin
                generation_reg <= generation_reg + 32'd1;
            end
            pend_valid_reg <= job_valid;
            hit_total_reg  <= hit_total_next;
            done_reg       <= pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg          <= job.op;
        pend_entry_valid_reg <= valid_reg[job.bucket];
        pend_position_reg    <= job.position;
        pend_rule_reg        <= job.rule_id;

        result_reg.hit           <= hit;
        result_reg.cached_result <= hit ? rd_entry.result : 32'sd0;
        result_reg.cached_start  <= hit ? rd_entry.start : 24'd0;
        result_reg.cached_count  <= hit ? rd_entry.count : 24'd0;
        result_reg.hits_so_far   <= hit_total_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_compare: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(pend_valid_reg))
        else $error("result strobe without a transaction in compare");

    a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.hit) |-> ($past(pend_op_reg) == OP_LOOKUP))
        else $error("hit reported for a non-lookup");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.hit) |-> (result_reg.cached_result == 32'sd0
            && result_reg.cached_start == 24'd0 && result_reg.cached_count == 24'd0))
        else $error("miss carries stale payload");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.hits_so_far == hit_total_reg))
        else $error("reported hit count differs from counter");

    a_count_moves_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_total_reg != $past(hit_total_reg)) |-> (done_reg && result_reg.hit))
        else $error("hit counter moved without a hit");

endmodule
`default_nettype wire

/* hdl/parse_memo_cache_top.sv */
// top level of the parse memo cache: front end, queue and back end
// usage:
//   command channel: drive item and raise start; the transaction is taken at a rising
//   edge with start high and busy low. busy guards a two-entry queue between the
//   hashing front end and the memory back end; since the back end drains one
//   transaction every cycle it stays low in normal use.
//   config: cfg_we with cfg_wdata writes cache_disabled at the edge; write it only
//   while no transaction is in flight.
//   result channel: every transaction (lookup, store, invalidate, unused mode) gives
//   one result, shown on result for exactly one cycle with done high. after
//   acceptance a transaction passes the queue, then the registered memory read,
//   then the tag compare is loaded into the output register as done rises. results
//   come in order.
//   throughput: one transaction per clock, set by the single memory port pair
//   (one read per transaction, one write per store) and the one-per-cycle back end.
//   the receiver cannot stall; done is a one-cycle strobe and must be taken.
//   reset: all entries invalid, generation and hit counter zero, cache enabled,
//   queue empty; entry contents are not cleared and need no clearing pass.
`default_nettype none
module parse_memo_cache_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pmc_pkg::item_t   item,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    output logic                  done,
    output pmc_pkg::result_t      result
);
    import pmc_pkg::*;

    logic job_valid;
    logic job_pop;
    job_t job;

    pmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    pmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire

/* test/parse_memo_cache_top_tb.sv */
// self-checking testbench for the parse memo cache top level
`timescale 1ns / 1ps

module parse_memo_cache_top_tb;

    import pmc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] position;
        logic [15:0] rule_id;
    } memo_key_t;

    typedef struct packed {
        logic    cfg_write;
        logic    cfg_value;
        logic    typed;
        item_t   cmd;
        result_t want;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    cfg_we;
    logic    cfg_wdata;
    logic    done;
    result_t result;

    // predictor state
    bit          memo_valid [ENTRIES];
    entry_t      memo_entry [ENTRIES];
    logic [31:0] memo_gen;
    logic [31:0] hit_count;
    bit          cache_off;

    // buckets ever written, so lookups never touch uninitialised storage
    bit          bucket_filled [ENTRIES];
    bucket_t     filled_list [$];
    memo_key_t   recent_keys [$];

    result_t     pending_results [$];
    int          mismatches;
    bit          gaps_on;

    dir_row_t directed_rows [26] = '{
        '{1'b1, 1'b0, 1'b1, '{MODE_STORE, 32'h0, 16'h0, 32'h7FFF_FFFF, 24'h0, 24'd128},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd0}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'h7FFF_FFFF, 24'h0, 24'd128, 32'd1}},
        '{1'b0, 1'b0, 1'b1,
          '{MODE_STORE, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd1}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 32'd2}},
        // matched length with too many records: nothing is stored
        '{1'b0, 1'b0, 1'b1, '{MODE_STORE, 32'h20, 16'h0, 32'd5, 24'd1, 24'd129},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd2}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'h7FFF_FFFF, 24'h0, 24'd128, 32'd3}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd3}},
        // zero is not a matched length, so a large count is still stored
        '{1'b0, 1'b0, 1'b1, '{MODE_STORE, 32'h20, 16'h0, 32'h0, 24'h12_3456, 24'hFF_FFFF},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd3}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'h0, 24'h12_3456, 24'hFF_FFFF, 32'd4}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd4}},
        // rule bits above bit 4 pick the top bucket
        '{1'b0, 1'b0, 1'b1, '{MODE_STORE, 32'h0, 16'h1FE0, 32'hFFFF_FFFF, 24'hAA, 24'd129},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd4}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h1FE0, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'hFFFF_FFFF, 24'hAA, 24'd129, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h1FFF, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_UNUSED, 32'h0, 16'h0, 32'd1, 24'd1, 24'd1},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_INVAL, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_STORE, 32'h20, 16'h0, 32'd1, 24'd3, 24'd128},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd5}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b1, 32'd1, 24'd3, 24'd128, 32'd6}},
        // cache switched off from here
        '{1'b1, 1'b1, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        '{1'b0, 1'b0, 1'b1, '{MODE_STORE, 32'h20, 16'h0, 32'd2, 24'd0, 24'd0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        '{1'b0, 1'b0, 1'b1, '{MODE_INVAL, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        '{1'b0, 1'b0, 1'b1, '{MODE_UNUSED, 32'h0, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        // back on: the invalidate while off has made the old entry stale
        '{1'b1, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h20, 16'h0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        '{1'b0, 1'b0, 1'b1, '{MODE_LOOKUP, 32'h0, 16'h1FE0, 32'h0, 24'h0, 24'h0},
          '{1'b0, 32'h0, 24'h0, 24'h0, 32'd6}},
        '{1'b0, 1'b0, 1'b0,
          '{MODE_STORE, 32'h1234_5678, 16'hBEEF, 32'h1000, 24'h00_ABCD, 24'h80}, '0},
        '{1'b0, 1'b0, 1'b0, '{MODE_LOOKUP, 32'h1234_5678, 16'hBEEF, 32'h0, 24'h0, 24'h0}, '0}
    };

    parse_memo_cache_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // works out the result of one transaction and advances the cache image
    function automatic result_t predict_memo(item_t it);
        result_t           r;
        logic [HASH_W-1:0] h;
        bucket_t           b;
        logic              positive;
        memo_key_t         k;
        r = '0;
        h = (HASH_W'(it.position) << POS_SHIFT) ^ (HASH_W'(it.rule_id) >> RULE_SHIFT);
        b = bucket_t'(h & BUCKET_MASK);
        positive = !it.match_result[31] && (it.match_result != 32'h0);
        case (it.mode)
            MODE_LOOKUP:
                if (!cache_off && memo_valid[b] && memo_entry[b].generation == memo_gen
                    && memo_entry[b].position == it.position
                    && memo_entry[b].rule_id == it.rule_id)
                begin
                    hit_count       = hit_count + 32'd1;
                    r.hit           = 1'b1;
                    r.cached_result = memo_entry[b].result;
                    r.cached_start  = memo_entry[b].start;
                    r.cached_count  = memo_entry[b].count;
                end
            MODE_STORE:
                if (!cache_off && !(positive && it.record_count > STORE_COUNT_LIMIT))
                begin
                    memo_valid[b] = 1'b1;
                    memo_entry[b] = '{it.position, it.rule_id, it.match_result,
                                      it.record_start, it.record_count, memo_gen};
                    if (!bucket_filled[b])
                    begin
                        bucket_filled[b] = 1'b1;
                        filled_list.push_back(b);
                    end
                    k.position = it.position;
                    k.rule_id  = it.rule_id;
                    recent_keys.push_back(k);
                    if (recent_keys.size() > 32)
                        recent_keys.delete(0);
                end
            MODE_INVAL:
                memo_gen = memo_gen + 32'd1;
            default:
                ;
        endcase
        r.hits_so_far = hit_count;
        return r;
    endfunction

    // bend the key so that it hashes to bucket b (8 index bits)
    function automatic void aim_at_bucket(inout item_t it, input bucket_t b);
        it.rule_id[7:5]  = b[2:0];
        it.position[4:0] = b[7:3] ^ it.rule_id[12:8];
    endfunction

    function automatic item_t make_item();
        item_t       it;
        memo_key_t   k;
        int unsigned pick;
        it.position     = $urandom();
        it.rule_id      = 16'($urandom());
        it.record_start = 24'($urandom());
        case ($urandom_range(3))
            0: it.match_result = $urandom();
            1: it.match_result = $urandom_range(1, 1000);
            2: it.match_result = -$signed(32'($urandom_range(0, 1000)));
            default: it.match_result = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        case ($urandom_range(3))
            0: it.record_count = 24'($urandom_range(127, 129));
            1: it.record_count = 24'($urandom_range(0, 300));
            2: it.record_count = 24'($urandom());
            default: it.record_count = 24'($urandom_range(0, 8));
        endcase
        pick = $urandom_range(99);
        if (filled_list.size() == 0 || (pick >= 48 && pick < 90))
        begin
            it.mode = MODE_STORE;
            pick = $urandom_range(99);
            // overwrite a live key, collide in a used bucket, or take a fresh key
            if (pick < 40 && recent_keys.size() != 0)
            begin
                k = recent_keys[$urandom_range(recent_keys.size() - 1)];
                it.position = k.position;
                it.rule_id  = k.rule_id;
            end
            else if (pick < 55 && filled_list.size() != 0)
                aim_at_bucket(it, filled_list[$urandom_range(filled_list.size() - 1)]);
        end
        else
        begin
            if (pick < 48)
                it.mode = MODE_LOOKUP;
            else if (pick < 95)
                it.mode = MODE_INVAL;
            else
                it.mode = MODE_UNUSED;
            if (it.mode == MODE_LOOKUP && recent_keys.size() != 0 && $urandom_range(99) < 70)
            begin
                k = recent_keys[$urandom_range(recent_keys.size() - 1)];
                it.position = k.position;
                it.rule_id  = k.rule_id;
            end
            else
                aim_at_bucket(it, filled_list[$urandom_range(filled_list.size() - 1)]);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_disabled(input logic value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cache_off = value;
    endtask

    task automatic send_transaction(input item_t it, input logic typed,
                                    input result_t typed_result);
        result_t predicted;
        while (gaps_on && $urandom_range(99) < 29)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_memo(it);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", result.hits_so_far, 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch("hit", 32'(result.hit), 32'(want.hit));
                if (result.cached_result !== want.cached_result)
                    report_mismatch("cached_result", result.cached_result, want.cached_result);
                if (result.cached_start !== want.cached_start)
                    report_mismatch("cached_start", 32'(result.cached_start),
                                    32'(want.cached_start));
                if (result.cached_count !== want.cached_count)
                    report_mismatch("cached_count", 32'(result.cached_count),
                                    32'(want.cached_count));
                if (result.hits_so_far !== want.hits_so_far)
                    report_mismatch("hits_so_far", result.hits_so_far, want.hits_so_far);
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int phase;
        int n;
        int guard;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        memo_gen   = '0;
        hit_count  = '0;
        cache_off  = 1'b0;
        mismatches = 0;
        gaps_on    = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < 26; r++)
        begin
            if (directed_rows[r].cfg_write)
                write_disabled(directed_rows[r].cfg_value);
            send_transaction(directed_rows[r].cmd, directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // enabled, disabled, enabled back to back with no gaps, enabled again
        for (phase = 0; phase < 4; phase++)
        begin
            write_disabled(phase == 1);
            gaps_on = (phase != 2);
            for (n = 0; n < ((phase == 1) ? 100 : 230); n++)
            begin
                if (phase == 3 && n == 100)
                    wait_drained();
                send_transaction(make_item(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing transactions", 32'h0, pending_results.size());
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
